// File: sv/pkn_pkg.sv
// Shared constants for the pose keypoint normaliser.
package pkn_pkg;
    localparam int JOINT_COUNT_DEF = 17;
    localparam int SHOULDER_A = 5;
    localparam int SHOULDER_B = 6;
    localparam int HIP_A = 11;
    localparam int HIP_B = 12;
    localparam logic [7:0] SCALE_RESET = 8'd40;
    localparam logic [14:0] Q14_ONE = 15'd16384;
endpackage

// File: sv/pkn_sqrt.sv
// Iterative integer square root, two result bits per cycle.
module pkn_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [43:0] i_value,
    output logic        o_busy,
    output logic [21:0] o_root
);
    logic [22:0] r_part;
    logic [43:0] r_val;
    logic [21:0] r_root;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic [24:0] p1, p2, c1, c2;
    logic [21:0] s1, s2;

    // two digit-recurrence steps per cycle
    always_comb begin
        p1 = {r_part, r_val[43:42]};
        c1 = {1'b0, r_root, 2'b01};
        if (p1 >= c1) begin
            p1 = p1 - c1;
            s1 = {r_root[20:0], 1'b1};
        end else begin
            s1 = {r_root[20:0], 1'b0};
        end
        p2 = {p1[22:0], r_val[41:40]};
        c2 = {1'b0, s1, 2'b01};
        if (p2 >= c2) begin
            p2 = p2 - c2;
            s2 = {s1[20:0], 1'b1};
        end else begin
            s2 = {s1[20:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd0;
            r_part <= '0;
            r_val  <= i_value;
            r_root <= '0;
        end else if (r_busy) begin
            r_part <= p2[22:0];
            r_val  <= {r_val[39:0], 4'd0};
            r_root <= s2;
            r_cnt  <= r_cnt + 4'd1;
            if (r_cnt == 4'd10) r_busy <= 1'b0;
        end
    end
    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

// File: sv/pkn_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pkn_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [36:0] i_num,
    input  logic [25:0] i_den,
    output logic        o_busy,
    output logic [36:0] o_quo
);
    logic [36:0] r_q;
    logic [25:0] r_r;
    logic [25:0] r_d;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [26:0] sh;
    always_comb sh = {r_r, r_q[36]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
            r_q <= i_num;
            r_r <= 26'd0;
            r_d <= i_den;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_d}) begin
                r_r <= 26'(sh - {1'b0, r_d});
                r_q <= {r_q[35:0], 1'b1};
            end else begin
                r_r <= sh[25:0];
                r_q <= {r_q[35:0], 1'b0};
            end
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd36) r_busy <= 1'b0;
        end
    end
    assign o_busy = r_busy;
    assign o_quo  = r_q;
endmodule

// File: sv/pose_keypoint_normalizer_top.sv
// Pose keypoint normaliser: loads a pose, then emits size-normalised points.
// Steps: a non-final point is stored; the final point starts the torso work (hip and
// shoulder reads, one square root) and a square root per point for the largest extent.
// Output: each point needs two divides, or none when degenerate, and waits until the
// previous result has left; input reopens with the last result.
// Reset: synchronous active low; clears load count, state and scale to 2.5.
module pose_keypoint_normalizer_top #(
    parameter int JOINT_COUNT = pkn_pkg::JOINT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_coord_x,
    input  logic [15:0]        i_coord_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic               o_last_point,
    output logic               o_degenerate
);
    localparam int AW = $clog2(JOINT_COUNT);
    localparam logic [14:0] Q14 = pkn_pkg::Q14_ONE;

    typedef enum logic [9:0] {
        S_LOAD  = 10'b0000000001,
        S_RDA   = 10'b0000000010,
        S_RDB   = 10'b0000000100,
        S_TORSO = 10'b0000001000,
        S_TWAIT = 10'b0000010000,
        S_PRD   = 10'b0000100000,
        S_PSQ   = 10'b0001000000,
        S_PWAIT = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    logic [31:0] r_mem [JOINT_COUNT];
    logic [31:0] r_rd;
    logic [AW-1:0] r_raddr;
    logic [7:0]  r_scale;
    logic [4:0]  r_cnt;
    t_state      r_state;
    logic [AW-1:0] r_j;
    logic [16:0] r_hx, r_hy, r_sx, r_sy;
    logic [1:0]  r_ph;
    logic [28:0] r_size;
    logic        r_dsq;
    logic        r_sel;
    logic        r_ov;
    logic signed [15:0] r_ox, r_oy;
    logic        r_ol, r_odg;
    logic signed [17:0] r_dx, r_dy;

    logic accept;
    assign o_stall = (r_state != S_LOAD);
    assign accept  = i_valid && !o_stall;

    // store and read port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    always_ff @(posedge i_clk) begin
        if (accept) r_mem[r_cnt[AW-1:0]] <= {i_coord_y, i_coord_x};
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    logic signed [17:0] tx, ty, cx, cy;
    logic [35:0] sq_x, sq_y;
    logic [43:0] sq_in;
    logic sq_start, sq_busy;
    logic [21:0] root;
    logic dv_start, dv_busy;
    logic [36:0] quo, num;
    logic [17:0] mag;

    always_comb begin
        tx = $signed({1'b0, r_sx}) - $signed({1'b0, r_hx});
        ty = $signed({1'b0, r_sy}) - $signed({1'b0, r_hy});
        cx = $signed({1'b0, r_rd[15:0], 1'b0}) - $signed({1'b0, r_hx});
        cy = $signed({1'b0, r_rd[31:16], 1'b0}) - $signed({1'b0, r_hy});
    end
    logic signed [17:0] vx, vy;
    assign vx = (r_state == S_TORSO) ? tx : cx;
    assign vy = (r_state == S_TORSO) ? ty : cy;
    assign sq_x = 36'($signed(vx) * $signed(vx));
    assign sq_y = 36'($signed(vy) * $signed(vy));
    assign sq_in = {1'b0, ({1'b0, sq_x[33:0]} + {1'b0, sq_y[33:0]}), 8'd0};
    assign sq_start = (r_state == S_TORSO) || (r_state == S_PSQ);

    pkn_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_value(sq_in), .o_busy(sq_busy), .o_root(root)
    );

    assign mag = r_sel ? (r_dy[17] ? 18'(-r_dy) : 18'(r_dy))
                       : (r_dx[17] ? 18'(-r_dx) : 18'(r_dx));
    assign num = {1'b0, mag, 18'd0} + {9'd0, r_size[28:1]};
    pkn_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_num(num), .i_den(r_size[25:0]), .o_busy(dv_busy), .o_quo(quo)
    );

    logic [29:0] tscaled;
    assign tscaled = 30'(root) * 30'(r_scale);
    logic [14:0] qsat;
    assign qsat = (quo > 37'(Q14)) ? Q14 : quo[14:0];
    logic signed [15:0] qs;
    assign qs = (r_sel ? r_dy[17] : r_dx[17]) ? -$signed({1'b0, qsat})
                                              : $signed({1'b0, qsat});

    always_comb begin
        rd_en = 1'b0; rd_addr = r_raddr; dv_start = 1'b0;
        unique case (r_state)
            S_LOAD:  begin rd_en = accept; rd_addr = AW'(pkn_pkg::HIP_A); end
            S_RDA:   begin rd_en = 1'b1; rd_addr = r_raddr; end
            S_RDB:   ;
            S_TORSO: ;
            S_TWAIT: ;
            S_PRD:   begin rd_en = 1'b1; rd_addr = r_j; end
            S_PSQ:   ;
            S_PWAIT: ;
            S_DIV:   begin
                rd_en = (r_ph == 2'd0);
                rd_addr = r_j;
                dv_start = (r_ph == 2'd2) && !dv_busy && !r_dsq && !r_ov
                           && (r_size != 29'd0);
            end
            S_OUT:   ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= 5'd0;
            r_scale <= pkn_pkg::SCALE_RESET;
            r_ov <= 1'b0;
            r_ph <= 2'd0;
            r_dsq <= 1'b0;
            r_sel <= 1'b0;
            r_j <= '0;
            r_ox <= '0;
            r_oy <= '0;
            r_ol <= 1'b0;
            r_odg <= 1'b0;
        end else begin
            if (i_cfg_we) r_scale <= i_cfg_data;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_LOAD: if (accept) begin
                    if (r_cnt == 5'(JOINT_COUNT - 1)) begin
                        r_cnt <= 5'd0;
                        r_state <= S_RDA;
                        r_ph <= 2'd0;
                        r_raddr <= AW'(pkn_pkg::HIP_B);
                    end else r_cnt <= r_cnt + 5'd1;
                end
                // gather hip and shoulder sums over four reads
                S_RDA: begin
                    r_ph <= r_ph + 2'd1;
                    unique case (r_ph)
                        2'd0: begin r_hx <= {1'b0, r_rd[15:0]}; r_hy <= {1'b0, r_rd[31:16]};
                            r_raddr <= AW'(pkn_pkg::SHOULDER_A); end
                        2'd1: begin r_hx <= r_hx + {1'b0, r_rd[15:0]};
                            r_hy <= r_hy + {1'b0, r_rd[31:16]};
                            r_raddr <= AW'(pkn_pkg::SHOULDER_B); end
                        2'd2: begin r_sx <= {1'b0, r_rd[15:0]}; r_sy <= {1'b0, r_rd[31:16]}; end
                        default: begin r_sx <= r_sx + {1'b0, r_rd[15:0]};
                            r_sy <= r_sy + {1'b0, r_rd[31:16]}; r_state <= S_RDB; end
                    endcase
                end
                S_RDB: r_state <= S_TORSO;
                S_TORSO: r_state <= S_TWAIT;
                S_TWAIT: if (!sq_busy) begin
                    r_size <= 29'(tscaled >> 4);
                    r_j <= '0;
                    r_state <= S_PRD;
                end
                S_PRD: r_state <= S_PSQ;
                S_PSQ: r_state <= S_PWAIT;
                S_PWAIT: if (!sq_busy) begin
                    if ({7'd0, root} > r_size) r_size <= {7'd0, root};
                    if (r_j == AW'(JOINT_COUNT - 1)) begin
                        r_j <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_j <= r_j + AW'(1);
                        r_state <= S_PRD;
                    end
                end
                // re-read point, then two divides (none when degenerate), then emit
                S_OUT: begin
                    r_state <= S_DIV;
                    r_sel <= 1'b0;
                    r_dsq <= 1'b0;
                    r_ph <= 2'd0;
                end
                S_DIV: begin
                    if (r_ph == 2'd0) begin r_ph <= 2'd1; end
                    else if (r_ph == 2'd1) begin
                        r_dx <= cx; r_dy <= cy; r_ph <= 2'd2;
                    end else if (r_size == 29'd0) begin
                        // hold until the previous item has left
                        if (!r_ov) begin
                            r_ox <= '0; r_oy <= '0; r_odg <= 1'b1;
                            r_ol <= (r_j == AW'(JOINT_COUNT - 1));
                            r_ov <= 1'b1;
                            r_ph <= 2'd0;
                            if (r_j == AW'(JOINT_COUNT - 1)) r_state <= S_LOAD;
                            else r_j <= r_j + AW'(1);
                        end
                    end else if (dv_start) begin
                        r_dsq <= 1'b1;
                    end else if (r_dsq && !dv_busy) begin
                        r_dsq <= 1'b0;
                        if (!r_sel) begin r_ox <= qs; r_sel <= 1'b1; end
                        else begin
                            r_oy <= qs; r_odg <= 1'b0; r_sel <= 1'b0;
                            r_ol <= (r_j == AW'(JOINT_COUNT - 1));
                            r_ov <= 1'b1; r_ph <= 2'd0;
                            if (r_j == AW'(JOINT_COUNT - 1)) r_state <= S_LOAD;
                            else r_j <= r_j + AW'(1);
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_norm_x = r_ox;
    assign o_norm_y = r_oy;
    assign o_last_point = r_ol;
    assign o_degenerate = r_odg;
endmodule

// File: sv/pkn_checker.sv
// Port-level checks for the pose keypoint normaliser.
module pkn_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_stall,
    input logic o_degenerate,
    input logic o_last_point,
    input logic signed [15:0] o_norm_x,
    input logic signed [15:0] o_norm_y
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_norm_x))
        else $error("stalled result changed");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_norm_x == 16'sd0 && o_norm_y == 16'sd0)
        else $error("degenerate result not zero");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_norm_x <= 16'sd16384 && o_norm_x >= -16'sd16384)
        else $error("norm_x out of range");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_point |-> o_stall)
        else $error("input taken during output");
endmodule

bind pose_keypoint_normalizer_top pkn_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_stall(o_stall), .o_degenerate(o_degenerate), .o_last_point(o_last_point),
    .o_norm_x(o_norm_x), .o_norm_y(o_norm_y)
);
